// File: rtl/pfdq_pkg.sv
// Package of the per-flow deferred queue dispatcher: result kinds, request
// codes, register indexes and default sizes. No dependencies.
package pfdq_pkg;

  localparam int unsigned FlowsDef     = 8;
  localparam int unsigned RingDepthDef = 16;
  localparam int unsigned MaxQuotaDef  = 8;
  localparam int unsigned MaxResults   = 64;

  typedef enum logic [1:0] {
    FUNC_ARRIVE = 2'd0,
    FUNC_DRAIN  = 2'd1,
    FUNC_CREDIT = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KIND_DIRECT   = 3'd0,
    KIND_DEFERRED = 3'd1,
    KIND_DRAINED  = 3'd2,
    KIND_DROP_INV = 3'd3,
    KIND_DROP_OVF = 3'd4,
    KIND_NO_PROG  = 3'd5,
    KIND_CREDIT   = 3'd6,
    KIND_RSVD     = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    REG_ACTIVE_FLOWS = 2'd0,
    REG_DEF_CAP      = 2'd1,
    REG_BUF_CAP      = 2'd2,
    REG_QUOTA        = 2'd3
  } reg_e;

endpackage

// File: rtl/per_flow_deferred_queue_dispatcher.sv
// Top level of the per-flow deferred queue dispatcher: sequencer, per-flow
// ring pointers, credit counters and drop counters. Uses pfdq_pkg, pfdq_ram.
//
// Requests enter on the s_axis channel (func in tuser, flow, handle and length
// in tdata) and results leave on m_axis (kind in tuser, last on tlast).
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle;
// the user is bound to this, as the block itself does not enforce it. An
// arrival, a credit return or a drain with nothing deferred has its single
// result written to the output register by the decide state once that register
// is free, and the next request can be accepted when the sequencer is back in
// idle. A drain pass first brings the cursor into the active flow range by
// repeated subtraction, visits every active flow in turn and moves each packet
// through the visit, read and emit states on the deferred store read port, with
// at most 64 moved packets. The input is not ready while a request is being
// worked on. Results go through a single output register; when the receiver
// stalls, the sequencer waits with it and no result is lost. After reset all
// rings, credit counters and drop counters are zero and no clearing pass is
// needed; the deferred store holds nothing meaningful until written.
module per_flow_deferred_queue_dispatcher
  import pfdq_pkg::*;
#(
  parameter int unsigned Flows     = FlowsDef,
  parameter int unsigned RingDepth = RingDepthDef,
  parameter int unsigned MaxQuota  = MaxQuotaDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: flow_id [7:0], pkt_handle [23:8], pkt_len [39:24]
  input  logic [39:0] s_axis_tdata,
  // tuser: func [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: out_flow [7:0], out_handle [23:8], out_len [39:24],
  //        route_error_count [71:40], overflow_drop_count [103:72],
  //        flow_drop_count [119:104]
  output logic [119:0] m_axis_tdata,
  // tuser: kind [2:0]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned FW  = (Flows > 1) ? $clog2(Flows) : 1;
  localparam int unsigned RW  = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam int unsigned CW  = $clog2(RingDepth + 1);
  localparam int unsigned AW  = $clog2(Flows * RingDepth) > 0 ? $clog2(Flows * RingDepth) : 1;
  localparam int unsigned DTW = $clog2(Flows * RingDepth + 1);
  localparam int unsigned QW  = $clog2(MaxQuota + 1);
  localparam int unsigned KW  = $clog2(MaxResults + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MOD,
    ST_VISIT,
    ST_READ,
    ST_EMIT,
    ST_WAIT
  } state_e;

  state_e state_q;

  logic [3:0] act_q;
  logic [4:0] dcap_q;
  logic [7:0] bcap_q;
  logic [3:0] quota_q;

  logic [RW-1:0]  head_q [Flows];
  logic [RW-1:0]  tail_q [Flows];
  logic [CW-1:0]  cnt_q  [Flows];
  logic [7:0]     occ_q  [Flows];
  logic [15:0]    fdrop_q [Flows];
  logic [DTW-1:0] dtotal_q;
  logic [FW-1:0]  cursor_q;
  logic [31:0]    rerr_q;
  logic [31:0]    odrop_q;

  logic [1:0]  func_q;
  logic [7:0]  fid_q;
  logic [15:0] hdl_q;
  logic [15:0] len_q;

  logic [FW-1:0] start_q;
  logic [FW-1:0] fcur_q;
  logic [FW:0]   visited_q;
  logic [QW-1:0] qcnt_q;
  logic [KW-1:0] moved_q;

  logic          pend_q;
  logic [FW-1:0] pflow_q;
  logic [15:0]   phdl_q;
  logic [15:0]   plen_q;

  logic        ov_q;
  logic [2:0]  okind_q;
  logic [7:0]  oflow_q;
  logic [15:0] ohdl_q;
  logic [15:0] olen_q;
  logic        olast_q;
  logic [31:0] orerr_q;
  logic [31:0] oodrop_q;
  logic [15:0] ofdrop_q;

  logic [4:0] nflows;
  logic [4:0] effcap;
  logic [3:0] effq;
  assign nflows = (32'(act_q) > Flows) ? 5'(Flows) : {1'b0, act_q};
  assign effcap = (32'(dcap_q) > RingDepth) ? 5'(RingDepth) : dcap_q;
  assign effq   = (32'(quota_q) > MaxQuota) ? 4'(MaxQuota) : quota_q;

  function automatic logic [RW-1:0] ring_next(input logic [RW-1:0] p, input logic [4:0] cap);
    logic [RW:0] n;
    n = {1'b0, p} + (RW+1)'(1);
    return (32'(n) >= 32'(cap) || 32'(n) >= RingDepth) ? '0 : RW'(n);
  endfunction

  function automatic logic [FW-1:0] next_flow(input logic [FW-1:0] f, input logic [4:0] n);
    logic [FW:0] x;
    x = {1'b0, f} + (FW+1)'(1);
    return (32'(x) >= 32'(n)) ? '0 : FW'(x);
  endfunction

  // Arrival decode on the registered request.
  logic          fid_ok;
  logic [FW-1:0] af;
  assign fid_ok = ({1'b0, fid_q} < 9'(nflows));
  assign af     = FW'(fid_q);

  // Drain step on the current flow.
  logic can_pop;
  assign can_pop = (32'(moved_q) < 32'(MaxResults)) && (cnt_q[fcur_q] != '0)
                 && (occ_q[fcur_q] < bcap_q) && (32'(qcnt_q) < 32'(effq));

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;
  logic          push_ok;

  assign push_ok   = (32'(cnt_q[af]) < 32'(effcap)) && (32'(tail_q[af]) < 32'(RingDepth));
  assign ram_we    = (state_q == ST_DECIDE) && (func_q == FUNC_ARRIVE) && fid_ok
                   && !((cnt_q[af] == '0) && (occ_q[af] < bcap_q)) && push_ok;
  assign ram_waddr = AW'(32'(af) * RingDepth + 32'(tail_q[af]));
  assign ram_raddr = AW'(32'(fcur_q) * RingDepth + 32'(head_q[fcur_q]));

  pfdq_ram #(
    .Width (32),
    .Depth (Flows * RingDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({hdl_q, len_q}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {ofdrop_q, oodrop_q, orerr_q, olen_q, ohdl_q, oflow_q};

  logic out_free;
  assign out_free = !ov_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      act_q     <= 4'd8;
      dcap_q    <= 5'd16;
      bcap_q    <= 8'd16;
      quota_q   <= 4'd8;
      dtotal_q  <= '0;
      cursor_q  <= '0;
      rerr_q    <= '0;
      odrop_q   <= '0;
      ov_q      <= 1'b0;
      pend_q    <= 1'b0;
      for (int i = 0; i < Flows; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        cnt_q[i]   <= '0;
        occ_q[i]   <= '0;
        fdrop_q[i] <= '0;
      end
    end else begin
      if (ov_q && m_axis_tready) begin
        ov_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_ACTIVE_FLOWS: act_q   <= cfg_data_i[3:0];
          REG_DEF_CAP:      dcap_q  <= cfg_data_i[4:0];
          REG_BUF_CAP:      bcap_q  <= cfg_data_i;
          REG_QUOTA:        quota_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            func_q  <= s_axis_tuser;
            fid_q   <= s_axis_tdata[7:0];
            hdl_q   <= s_axis_tdata[23:8];
            len_q   <= s_axis_tdata[39:24];
            state_q <= (s_axis_tuser == FUNC_NONE) ? ST_IDLE : ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            ov_q    <= 1'b1;
            oflow_q <= fid_q;
            ohdl_q  <= hdl_q;
            olen_q  <= len_q;
            olast_q <= 1'b1;
            state_q <= ST_IDLE;
            unique case (func_q)
              FUNC_ARRIVE: begin
                orerr_q  <= rerr_q;
                oodrop_q <= odrop_q;
                ofdrop_q <= (32'(fid_q) < Flows) ? fdrop_q[af] : 16'd0;
                if (!fid_ok) begin
                  okind_q <= KIND_DROP_INV;
                  if (rerr_q != '1) begin
                    rerr_q  <= rerr_q + 32'd1;
                    orerr_q <= rerr_q + 32'd1;
                  end
                end else if (cnt_q[af] == '0 && occ_q[af] < bcap_q) begin
                  okind_q    <= KIND_DIRECT;
                  occ_q[af]  <= occ_q[af] + 8'd1;
                end else if (push_ok) begin
                  okind_q    <= KIND_DEFERRED;
                  tail_q[af] <= ring_next(tail_q[af], effcap);
                  cnt_q[af]  <= cnt_q[af] + CW'(1);
                  dtotal_q   <= dtotal_q + DTW'(1);
                end else begin
                  okind_q <= KIND_DROP_OVF;
                  if (rerr_q != '1) begin
                    rerr_q  <= rerr_q + 32'd1;
                    orerr_q <= rerr_q + 32'd1;
                  end
                  if (odrop_q != '1) begin
                    odrop_q  <= odrop_q + 32'd1;
                    oodrop_q <= odrop_q + 32'd1;
                  end
                  if (fdrop_q[af] != '1) begin
                    fdrop_q[af] <= fdrop_q[af] + 16'd1;
                    ofdrop_q    <= fdrop_q[af] + 16'd1;
                  end
                end
              end
              FUNC_CREDIT: begin
                okind_q  <= KIND_CREDIT;
                ohdl_q   <= '0;
                olen_q   <= '0;
                orerr_q  <= rerr_q;
                oodrop_q <= odrop_q;
                ofdrop_q <= (32'(fid_q) < Flows) ? fdrop_q[af] : 16'd0;
                if (fid_ok && occ_q[af] != '0) begin
                  occ_q[af] <= occ_q[af] - 8'd1;
                end
              end
              default: begin
                if (nflows != '0 && dtotal_q != '0) begin
                  ov_q      <= 1'b0;
                  start_q   <= cursor_q;
                  visited_q <= '0;
                  qcnt_q    <= '0;
                  moved_q   <= '0;
                  state_q   <= ST_MOD;
                end else begin
                  okind_q  <= KIND_NO_PROG;
                  oflow_q  <= '0;
                  ohdl_q   <= '0;
                  olen_q   <= '0;
                  orerr_q  <= rerr_q;
                  oodrop_q <= odrop_q;
                  ofdrop_q <= fdrop_q[0];
                end
              end
            endcase
          end
        end
        ST_MOD: begin
          if (32'(start_q) >= 32'(nflows)) begin
            start_q <= start_q - FW'(nflows);
          end else begin
            fcur_q  <= start_q;
            state_q <= ST_VISIT;
          end
        end
        ST_VISIT: begin
          if (32'(visited_q) >= 32'(nflows)) begin
            cursor_q <= next_flow(start_q, nflows);
            state_q  <= ST_WAIT;
          end else if (can_pop) begin
            state_q <= ST_READ;
          end else begin
            fcur_q    <= next_flow(fcur_q, nflows);
            visited_q <= visited_q + (FW+1)'(1);
            qcnt_q    <= '0;
          end
        end
        ST_READ: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!pend_q || out_free) begin
            if (pend_q) begin
              ov_q     <= 1'b1;
              okind_q  <= KIND_DRAINED;
              oflow_q  <= 8'(pflow_q);
              ohdl_q   <= phdl_q;
              olen_q   <= plen_q;
              olast_q  <= 1'b0;
              orerr_q  <= rerr_q;
              oodrop_q <= odrop_q;
              ofdrop_q <= fdrop_q[pflow_q];
            end
            pend_q  <= 1'b1;
            pflow_q <= fcur_q;
            phdl_q  <= ram_rdata[31:16];
            plen_q  <= ram_rdata[15:0];
            head_q[fcur_q] <= ring_next(head_q[fcur_q], effcap);
            cnt_q[fcur_q]  <= cnt_q[fcur_q] - CW'(1);
            occ_q[fcur_q]  <= occ_q[fcur_q] + 8'd1;
            if (dtotal_q != '0) begin
              dtotal_q <= dtotal_q - DTW'(1);
            end
            qcnt_q  <= qcnt_q + QW'(1);
            moved_q <= moved_q + KW'(1);
            state_q <= ST_VISIT;
          end
        end
        ST_WAIT: begin
          if (out_free) begin
            ov_q     <= 1'b1;
            olast_q  <= 1'b1;
            orerr_q  <= rerr_q;
            oodrop_q <= odrop_q;
            state_q  <= ST_IDLE;
            if (moved_q == '0) begin
              okind_q  <= KIND_NO_PROG;
              oflow_q  <= '0;
              ohdl_q   <= '0;
              olen_q   <= '0;
              ofdrop_q <= fdrop_q[0];
            end else begin
              okind_q  <= KIND_DRAINED;
              oflow_q  <= 8'(pflow_q);
              ohdl_q   <= phdl_q;
              olen_q   <= plen_q;
              ofdrop_q <= fdrop_q[pflow_q];
              pend_q   <= 1'b0;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // A drained packet is held back by one until the next one or the end of the
  // pass is known, so that the last flag lands on the final result.

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == ST_IDLE))
    else $error("input ready outside idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && (!pend_q || out_free)) |=> (moved_q != '0))
    else $error("drain emit did not count a moved packet");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !m_axis_tready) |=> ov_q && $stable(okind_q) && $stable(olast_q)
      && $stable(m_axis_tdata))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(moved_q) <= 32'(MaxResults)))
    else $error("drain moved too many packets");

endmodule

// File: rtl/pfdq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pfdq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
